### hw/rtl/wrapped_text_page_ring_buffer_unit_defines.svh
// Shared assertion macros
`ifndef WRAPPED_TEXT_PAGE_RING_BUFFER_UNIT_DEFINES_SVH
`define WRAPPED_TEXT_PAGE_RING_BUFFER_UNIT_DEFINES_SVH

// Same-cycle implication
`define WTPR_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("wtpr assertion failed");

// Next-cycle implication
`define WTPR_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("wtpr assertion failed");

`endif

### hw/rtl/wtpr_pkg.sv
package wtpr_pkg;

    // actions
    localparam logic [2:0] ACT_CLEAR = 3'd0;
    localparam logic [2:0] ACT_PUT   = 3'd1;
    localparam logic [2:0] ACT_END   = 3'd2;
    localparam logic [2:0] ACT_OPEN  = 3'd3;
    localparam logic [2:0] ACT_READ  = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OVERFLOW = 3'd1;
    localparam logic [2:0] ST_REJECT   = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_END      = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_LINE_WIDTH = 2'd0;
    localparam logic [1:0] CFG_LPP        = 2'd1;
    localparam logic [1:0] CFG_MAX_PAGES  = 2'd2;
    localparam logic [1:0] CFG_OVERWRITE  = 2'd3;

    // special bytes
    localparam logic [7:0] LINE_DELIM = 8'h1f;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ESC     = 8'h1b;
    localparam logic [7:0] CH_CSI     = 8'h5b;
    localparam logic [7:0] CSI_LO     = 8'h40;
    localparam logic [7:0] CSI_HI     = 8'h7e;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] char_in;
        logic [5:0] indent;
        logic       first_of_string;
        logic [7:0] page_number;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  char_out;
        logic [7:0]  page_count;
        logic [10:0] line_count;
    } t_out_item;

endpackage

### hw/rtl/wrapped_text_page_ring_buffer_unit.sv
// Wrapped text page ring buffer.
// Input channel (i_in_valid / o_in_stall / i_in_item) carries one action per
// transfer: clear, put character, end string, open page, read next. Every
// action returns exactly one result on the output channel (o_out_valid /
// i_out_stall / o_out_item) with status, character and the stored line and
// page counts. Items are handled one at a time by a sequencer around a
// single-port-write, registered-read character RAM.
// Clear, unused codes, rejected or dropped puts and out-of-range opens go
// straight to the result. A put inserts any indent spaces, the character and
// then a wrap delimiter if the line fills. End inserts padding spaces and a
// delimiter, then waits for the page count divider, as does a rejected end;
// an end after dropped bytes, or one that drops its last bytes, skips the
// divider. Each write into a full ring with overwrite on first reads the
// oldest byte. Open walks the ring byte by byte over earlier lines; read
// walks past delimiters to the next character or the page end. The next item
// is taken the cycle after its result is loaded, even while that result
// waits.
// Reset clears all control state and empties the ring; configuration returns
// to width 16, 7 lines per page, 255 pages, overwrite off. A stalled result
// holds in the output register and the sequencer waits before issuing the next.
module wrapped_text_page_ring_buffer_unit #(
    parameter int BUF_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  wtpr_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output wtpr_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [7:0]          i_cfg_data
);

    `include "wrapped_text_page_ring_buffer_unit_defines.svh"

    localparam int AW = $clog2(BUF_DEPTH);
    localparam int LW = AW + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PAD    = 4'd1;
    localparam logic [3:0] S_CHAR2  = 4'd2;
    localparam logic [3:0] S_PUTFIN = 4'd3;
    localparam logic [3:0] S_EPAD   = 4'd4;
    localparam logic [3:0] S_EFIN   = 4'd5;
    localparam logic [3:0] S_INS    = 4'd6;
    localparam logic [3:0] S_HEADRD = 4'd7;
    localparam logic [3:0] S_DIVGO  = 4'd8;
    localparam logic [3:0] S_DIV    = 4'd9;
    localparam logic [3:0] S_OWALK  = 4'd10;
    localparam logic [3:0] S_OWAIT  = 4'd11;
    localparam logic [3:0] S_RWALK  = 4'd12;
    localparam logic [3:0] S_RWAIT  = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    // escape tracker: returns {counts_as_escape, next_state}
    function automatic logic [2:0] esc_step(input logic [1:0] st, input logic [7:0] c);
        logic [1:0] nx;
        nx = st;
        if (st == 2'd0 && c == wtpr_pkg::CH_ESC) begin
            nx = 2'd1;
        end else if (st == 2'd1) begin
            nx = (c == wtpr_pkg::CH_CSI) ? 2'd2 : 2'd0;
        end else if (st == 2'd2 && c >= wtpr_pkg::CSI_LO && c <= wtpr_pkg::CSI_HI) begin
            nx = 2'd0;
        end
        return {(st != 2'd0) || (nx != 2'd0), nx};
    endfunction

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] i);
        return (i == AW'(BUF_DEPTH - 1)) ? '0 : AW'(i + 1'b1);
    endfunction

    // configuration
    logic [5:0] r_width;
    logic [3:0] r_lpp;
    logic [7:0] r_max;
    logic       r_ow;

    // control state
    logic [3:0]    r_state, n_state;
    logic [3:0]    r_ret, n_ret;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [LW-1:0] r_lines, n_lines;
    logic [7:0]    r_pages, n_pages;
    logic [1:0]    r_esc, n_esc;
    logic [5:0]    r_pos, n_pos;
    logic          r_drop, n_drop;
    logic          r_rej, n_rej;
    logic [AW-1:0] r_cursor, n_cursor;
    logic [3:0]    r_rline, n_rline;
    logic          r_active, n_active;
    logic [5:0]    r_cnt, n_cnt;
    logic [11:0]   r_oline, n_oline;
    logic          r_ov;

    // payload
    wtpr_pkg::t_in_item  r_item;
    logic [7:0]          r_byte, n_byte;
    logic [2:0]          r_st, n_st;
    logic [7:0]          r_ch, n_ch;
    logic [11:0]         r_target, n_target;
    wtpr_pkg::t_out_item r_out;

    logic          w_acc;
    logic          w_we;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata;
    logic          w_full;
    logic [3:0]    w_lpp;
    logic          w_div_start;
    logic          w_div_done;
    logic [LW-1:0] w_quo;
    logic          w_rem_nz;
    logic [LW:0]   w_p;
    logic [LW+8:0] w_p_ext;
    logic [LW+8:0] w_max_ext;
    logic [LW+10:0] w_lines_ext;
    logic          w_load;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_full     = (nxt(r_tail) == r_head);
    assign w_lpp      = (r_lpp == 4'd0) ? 4'd1 : r_lpp;
    assign w_raddr    = (r_state == S_INS) ? r_head : r_cursor;
    assign w_load     = (r_state == S_OUT) && (!r_ov || !i_out_stall);

    wtpr_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_ring (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_tail),
        .i_wdata(r_byte),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    wtpr_div #(.W(LW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_lines),
        .i_den   (w_lpp),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem_nz(w_rem_nz)
    );

    // capped page count
    assign w_p       = {1'b0, w_quo} + (LW+1)'(w_rem_nz);
    assign w_p_ext   = (LW+9)'(w_p);
    assign w_max_ext = (LW+9)'(r_max);

    // sequencer
    always_comb begin
        logic       v_drop;
        logic       v_rej;
        logic [5:0] v_pos;
        logic [2:0] v_e;
        logic [5:0] v_np;
        n_state = r_state;   n_ret = r_ret;       n_head = r_head;
        n_tail = r_tail;     n_lines = r_lines;   n_pages = r_pages;
        n_esc = r_esc;       n_pos = r_pos;       n_drop = r_drop;
        n_rej = r_rej;       n_cursor = r_cursor; n_rline = r_rline;
        n_active = r_active; n_cnt = r_cnt;       n_oline = r_oline;
        n_byte = r_byte;     n_st = r_st;         n_ch = r_ch;
        n_target = r_target;
        w_we = 1'b0;
        w_div_start = 1'b0;
        v_drop = 1'b0; v_rej = 1'b0; v_pos = '0; v_e = '0; v_np = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_st = wtpr_pkg::ST_OK;
                    n_ch = 8'd0;
                    n_state = S_OUT;
                    case (i_in_item.action)
                        wtpr_pkg::ACT_CLEAR: begin
                            n_head = '0; n_tail = '0; n_lines = '0; n_pages = 8'd1;
                            n_esc = '0; n_pos = '0; n_drop = 1'b0; n_rej = 1'b0;
                            n_cursor = '0; n_rline = '0; n_active = 1'b0;
                        end
                        wtpr_pkg::ACT_PUT: begin
                            v_pos  = i_in_item.first_of_string ? 6'd0 : r_pos;
                            v_drop = i_in_item.first_of_string ? 1'b0 : r_drop;
                            v_rej  = i_in_item.first_of_string ? 1'b0 : r_rej;
                            n_pos = v_pos; n_drop = v_drop; n_rej = v_rej;
                            if (v_rej) begin
                                n_st = wtpr_pkg::ST_REJECT;
                            end else if (v_drop) begin
                                v_e = esc_step(r_esc, i_in_item.char_in);
                                n_esc = v_e[1:0];
                                n_st = wtpr_pkg::ST_OVERFLOW;
                            end else if (i_in_item.indent > r_width) begin
                                n_rej = 1'b1;
                                n_st = wtpr_pkg::ST_REJECT;
                            end else begin
                                n_cnt = '0;
                                if (v_pos == 6'd0) begin
                                    n_cnt = i_in_item.indent;
                                    n_pos = i_in_item.indent;
                                end
                                n_state = S_PAD;
                            end
                        end
                        wtpr_pkg::ACT_END: begin
                            v_rej = r_rej || (!r_drop && (i_in_item.indent > r_width));
                            if (v_rej) begin
                                n_pos = '0; n_drop = 1'b0; n_rej = 1'b0;
                                n_st = wtpr_pkg::ST_REJECT;
                                n_state = S_DIVGO;
                            end else if (r_drop) begin
                                n_pos = '0; n_drop = 1'b0; n_rej = 1'b0;
                                n_st = wtpr_pkg::ST_OVERFLOW;
                            end else begin
                                n_cnt = (r_width > r_pos) ? 6'(r_width - r_pos) : 6'd0;
                                n_state = S_EPAD;
                            end
                        end
                        wtpr_pkg::ACT_OPEN: begin
                            if (i_in_item.page_number == 8'd0 ||
                                i_in_item.page_number > r_pages) begin
                                n_active = 1'b0;
                                n_st = wtpr_pkg::ST_RANGE;
                            end else begin
                                n_target = 12'(8'(i_in_item.page_number - 8'd1) * w_lpp);
                                n_oline = '0;
                                n_cursor = r_head;
                                n_state = S_OWALK;
                            end
                        end
                        wtpr_pkg::ACT_READ: begin
                            n_state = S_RWALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PAD: begin
                n_state = S_INS;
                if (r_cnt != 6'd0) begin
                    n_byte = wtpr_pkg::CH_SPACE;
                    n_cnt = r_cnt - 6'd1;
                    n_ret = S_PAD;
                end else begin
                    n_byte = r_item.char_in;
                    n_ret = S_CHAR2;
                end
            end
            S_CHAR2: begin
                v_e = esc_step(r_esc, r_item.char_in);
                n_esc = v_e[1:0];
                n_state = S_PUTFIN;
                if (!v_e[2]) begin
                    v_np = r_pos + 6'd1;
                    n_pos = v_np;
                    if (v_np >= r_width) begin
                        n_pos = '0;
                        n_byte = wtpr_pkg::LINE_DELIM;
                        n_ret = S_PUTFIN;
                        n_state = S_INS;
                    end
                end
            end
            S_PUTFIN: begin
                n_st = r_drop ? wtpr_pkg::ST_OVERFLOW : wtpr_pkg::ST_OK;
                n_state = S_OUT;
            end
            S_EPAD: begin
                n_state = S_INS;
                if (r_cnt != 6'd0) begin
                    n_byte = wtpr_pkg::CH_SPACE;
                    n_cnt = r_cnt - 6'd1;
                    n_ret = S_EPAD;
                end else begin
                    n_byte = wtpr_pkg::LINE_DELIM;
                    n_ret = S_EFIN;
                end
            end
            S_EFIN: begin
                n_pos = '0; n_drop = 1'b0; n_rej = 1'b0;
                if (r_drop) begin
                    n_st = wtpr_pkg::ST_OVERFLOW;
                    n_state = S_OUT;
                end else begin
                    n_st = wtpr_pkg::ST_OK;
                    n_state = S_DIVGO;
                end
            end
            // one ring insert; full ring reads the oldest byte first if overwrite is on, else drops
            S_INS: begin
                if (r_drop) begin
                    n_state = r_ret;
                end else if (w_full && !r_ow) begin
                    n_drop = 1'b1;
                    n_state = r_ret;
                end else if (w_full) begin
                    n_state = S_HEADRD;
                end else begin
                    w_we = 1'b1;
                    n_tail = nxt(r_tail);
                    if (r_byte == wtpr_pkg::LINE_DELIM) begin
                        n_lines = r_lines + 1'b1;
                    end
                    n_state = r_ret;
                end
            end
            S_HEADRD: begin
                w_we = 1'b1;
                n_tail = nxt(r_tail);
                n_head = nxt(r_head);
                n_lines = r_lines
                    - LW'(w_rdata == wtpr_pkg::LINE_DELIM && r_lines != '0)
                    + LW'(r_byte == wtpr_pkg::LINE_DELIM);
                n_state = r_ret;
            end
            S_DIVGO: begin
                w_div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_pages = (w_p_ext > w_max_ext) ? r_max : w_p_ext[7:0];
                    n_state = S_OUT;
                end
            end
            // open: skip earlier lines
            S_OWALK: begin
                if (r_oline < r_target && r_cursor != r_tail) begin
                    n_state = S_OWAIT;
                end else begin
                    n_rline = w_lpp;
                    n_active = 1'b1;
                    n_st = wtpr_pkg::ST_OK;
                    n_state = S_OUT;
                end
            end
            S_OWAIT: begin
                if (w_rdata == wtpr_pkg::LINE_DELIM) begin
                    n_oline = r_oline + 12'd1;
                end
                n_cursor = nxt(r_cursor);
                n_state = S_OWALK;
            end
            // read: skip delimiters, return next character
            S_RWALK: begin
                if (r_active && r_rline != 4'd0 && r_cursor != r_tail) begin
                    n_state = S_RWAIT;
                end else begin
                    n_active = 1'b0;
                    n_st = wtpr_pkg::ST_END;
                    n_state = S_OUT;
                end
            end
            S_RWAIT: begin
                n_cursor = nxt(r_cursor);
                if (w_rdata == wtpr_pkg::LINE_DELIM) begin
                    n_rline = r_rline - 4'd1;
                    n_state = S_RWALK;
                end else begin
                    n_ch = w_rdata;
                    n_st = wtpr_pkg::ST_OK;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;   r_ret <= S_IDLE;
            r_head <= '0;        r_tail <= '0;
            r_lines <= '0;       r_pages <= 8'd1;
            r_esc <= '0;         r_pos <= '0;
            r_drop <= 1'b0;      r_rej <= 1'b0;
            r_cursor <= '0;      r_rline <= '0;
            r_active <= 1'b0;    r_cnt <= '0;
            r_oline <= '0;       r_ov <= 1'b0;
            r_width <= 6'd16;    r_lpp <= 4'd7;
            r_max <= 8'd255;     r_ow <= 1'b0;
        end else begin
            r_state <= n_state;   r_ret <= n_ret;
            r_head <= n_head;     r_tail <= n_tail;
            r_lines <= n_lines;   r_pages <= n_pages;
            r_esc <= n_esc;       r_pos <= n_pos;
            r_drop <= n_drop;     r_rej <= n_rej;
            r_cursor <= n_cursor; r_rline <= n_rline;
            r_active <= n_active; r_cnt <= n_cnt;
            r_oline <= n_oline;
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    wtpr_pkg::CFG_LINE_WIDTH: r_width <= i_cfg_data[5:0];
                    wtpr_pkg::CFG_LPP:        r_lpp   <= i_cfg_data[3:0];
                    wtpr_pkg::CFG_MAX_PAGES:  r_max   <= i_cfg_data;
                    wtpr_pkg::CFG_OVERWRITE:  r_ow    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    assign w_lines_ext = (LW+11)'(r_lines);

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item <= i_in_item;
        end
        r_byte   <= n_byte;
        r_st     <= n_st;
        r_ch     <= n_ch;
        r_target <= n_target;
        if (w_load) begin
            r_out.status     <= r_st;
            r_out.char_out   <= r_ch;
            r_out.page_count <= r_pages;
            r_out.line_count <= w_lines_ext[10:0];
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    `WTPR_ASSERT_NXT(a_clear_empties, i_clk, i_rst_n,
        w_acc && i_in_item.action == wtpr_pkg::ACT_CLEAR,
        r_head == r_tail && r_lines == '0 && r_state == S_OUT)
    `WTPR_ASSERT_NOW(a_no_write_when_dropped, i_clk, i_rst_n, w_we, !r_drop)
    `WTPR_ASSERT_NOW(a_no_write_idle, i_clk, i_rst_n, r_state == S_IDLE, !w_we)

endmodule

### hw/rtl/wtpr_ram.sv
module wtpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hw/rtl/wtpr_div.sv
// Restoring divider, one quotient bit per cycle
module wtpr_div #(
    parameter int W = 11
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [3:0]   i_den,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic         o_rem_nz
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_num;
    logic [3:0]    r_rem;
    logic [3:0]    r_den;
    logic          r_done;
    logic [4:0]    w_sh;
    logic          w_ge;

    assign w_sh = {r_rem, r_num[W-1]};
    assign w_ge = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: shift in dividend bits, quotient shifts into r_num
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? 4'(w_sh - {1'b0, r_den}) : w_sh[3:0];
            r_num <= {r_num[W-2:0], w_ge};
        end
    end

    assign o_done   = r_done;
    assign o_quo    = r_num;
    assign o_rem_nz = (r_rem != 4'd0);

endmodule
